// ===== hdl/pdae_pkg.sv =====
// ----------------------------------------------------------------------------
// pdae_pkg
// Shared types and constants of the phase-driven ADSR envelope generator.
// ----------------------------------------------------------------------------
package pdae_pkg;

  localparam int unsigned GateThreshold  = 66;
  localparam int unsigned ElapsedBitsDef = 20;

  // bend scale factors, 0.99999 and 0.999999 in Q32
  localparam logic [31:0] KA = 32'd4294924346;
  localparam logic [31:0] KB = 32'd4294963001;

  localparam logic [16:0] OneQ16 = 17'd65536;

  typedef enum logic [2:0] {
    STG_ATTACK  = 3'd0,
    STG_DECAY   = 3'd1,
    STG_SUSTAIN = 3'd2,
    STG_RELEASE = 3'd3,
    STG_END     = 3'd4
  } stage_e;

  typedef enum logic [2:0] {
    CFG_ATTACK_TIME   = 3'd0,
    CFG_DECAY_TIME    = 3'd1,
    CFG_SUSTAIN_LEVEL = 3'd2,
    CFG_RELEASE_TIME  = 3'd3,
    CFG_HOLD_TIME     = 3'd4,
    CFG_ATTACK_CURVE  = 3'd5,
    CFG_DECAY_CURVE   = 3'd6,
    CFG_RELEASE_CURVE = 3'd7
  } cfg_idx_e;

  // what the level of one beat needs after the state update
  typedef enum logic [2:0] {
    JOB_NONE   = 3'd0,
    JOB_SUS    = 3'd1,
    JOB_EASE_A = 3'd2,
    JOB_EASE_D = 3'd3,
    JOB_EASE_R = 3'd4
  } job_e;

endpackage

// ===== hdl/phase_driven_adsr_envelope.sv =====
// ----------------------------------------------------------------------------
// phase_driven_adsr_envelope
// One-channel ADSR envelope with hold, timed by phasor samples, Q16.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (phase_i, gate_level_i, gate_event_i) are taken when in_valid_i
//   is high and in_stall_o low. Each input beat gives exactly one output beat
//   (level_o, voice_active_o, env_stage_o) on out_valid_o / out_stall_i.
//   Registers are written over cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i; the user must write them only while no beat is in flight, as
//   the block itself does not enforce it. One beat is worked at a time by a
//   bit-serial shift-add multiplier and a radix-2 restoring divider that retire
//   one bit per cycle. A beat that has ended or takes its level straight from
//   the gate skips both units; a bent curve stage takes longest, with the
//   52-step bend divide and up to nine serial multiplies of at most 18 steps.
//   The multiplier stops early once its multiplier operand runs out of ones.
//   A new input beat is taken as soon as the sequencer is idle, even while the
//   previous result still waits in the output register; a stalled output holds
//   its beat and the sequencer waits before loading the next one.
//   Reset puts the envelope in the ended stage with all timers cleared and
//   loads the register reset values (sustain at 1.0, everything else zero).
module phase_driven_adsr_envelope
  import pdae_pkg::*;
#(
  parameter int unsigned ElapsedBits = ElapsedBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] phase_i,
  input  logic [16:0] gate_level_i,
  input  logic        gate_event_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] level_o,
  output logic        voice_active_o,
  output logic [2:0]  env_stage_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned EB = ElapsedBits;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SUS  = 13'b0000000000010,
    S_FRAC = 13'b0000000000100,
    S_QB   = 13'b0000000001000,
    S_QA   = 13'b0000000010000,
    S_T    = 13'b0000000100000,
    S_NUM  = 13'b0000001000000,
    S_BDIV = 13'b0000010000000,
    S_P2   = 13'b0000100000000,
    S_P3   = 13'b0001000000000,
    S_MIX1 = 13'b0010000000000,
    S_MIX2 = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } seq_e;

  // configuration
  logic [16:0] at_q, dt_q, sl_q, rt_q, ht_q;
  logic [16:0] ac_q, dc_q, rc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_q <= '0;
      dt_q <= '0;
      sl_q <= OneQ16;
      rt_q <= '0;
      ht_q <= '0;
      ac_q <= '0;
      dc_q <= '0;
      rc_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ATTACK_TIME:   at_q <= cfg_data_i;
        CFG_DECAY_TIME:    dt_q <= cfg_data_i;
        CFG_SUSTAIN_LEVEL: sl_q <= cfg_data_i;
        CFG_RELEASE_TIME:  rt_q <= cfg_data_i;
        CFG_HOLD_TIME:     ht_q <= cfg_data_i;
        CFG_ATTACK_CURVE:  ac_q <= cfg_data_i;
        CFG_DECAY_CURVE:   dc_q <= cfg_data_i;
        CFG_RELEASE_CURVE: rc_q <= cfg_data_i;
      endcase
    end
  end

  // envelope state
  stage_e         stage_q;
  logic [16:0]    gp_q, rs_q, last_q;
  logic [15:0]    prev_q;
  logic [EB-1:0]  el_q, hold_q;
  job_e           job_q;

  // sequencer and serial units
  seq_e           seq_q;
  logic           run_q;
  logic [17:0]    mul_b_q;
  logic [52:0]    mul_a_q, acc_q;
  logic [5:0]     div_cnt_q;
  logic [36:0]    rem_q;
  logic [51:0]    num_q;
  logic [16:0]    dq_q;
  logic           ovf_q;
  logic [35:0]    dsr_q;

  // intermediate results
  logic [16:0]    sus_q, v_q, p_q, w_q, lvl_q;
  logic [32:0]    qb_q;
  logic [33:0]    qa_q;
  logic [34:0]    n_q;
  logic [35:0]    den_q;
  logic [32:0]    p2_q;

  // output register
  logic           out_valid_q;
  logic [16:0]    out_level_q;
  logic           out_active_q;
  logic [2:0]     out_stage_q;

  logic in_acc, out_free, op_fin;

  assign in_stall_o = (seq_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign level_o        = out_level_q;
  assign voice_active_o = out_active_q;
  assign env_stage_o    = out_stage_q;

  // ---------------------------------------------------------------------------
  // per-beat state update
  // ---------------------------------------------------------------------------
  stage_e        stg;
  logic [EB-1:0] el, hel;
  logic [15:0]   pp;
  logic [16:0]   gp, rs, lvl;
  job_e          job;

  always_comb begin
    logic          was_off, is_on, onset;
    logic [16:0]   gdiff, pdiff;
    logic [15:0]   adv;
    logic [EB:0]   hsum, esum;
    stg   = stage_q;
    el    = el_q;
    hel   = hold_q;
    pp    = prev_q;
    gp    = gp_q;
    rs    = rs_q;
    lvl   = '0;
    job   = JOB_NONE;
    was_off = (last_q <= 17'(GateThreshold));
    is_on   = (gate_level_i > 17'(GateThreshold));
    onset   = 1'b0;
    gdiff   = (gate_level_i > gp_q) ? gate_level_i - gp_q : gp_q - gate_level_i;
    if (was_off && is_on) begin
      onset = 1'b1;
    end else if (!was_off && !is_on) begin
      if (ht_q == '0) begin
        stg = (rt_q != '0) ? STG_RELEASE : STG_END;
        el  = '0;
      end
    end else if (is_on) begin
      if (gate_event_i || gdiff > 17'(GateThreshold)) onset = 1'b1;
    end
    if (onset) begin
      gp = gate_level_i;
      if (at_q == '0) stg = (dt_q == '0) ? STG_SUSTAIN : STG_DECAY;
      else            stg = STG_ATTACK;
      hel = '0;
      pp  = phase_i;
      el  = '0;
      rs  = gate_level_i;
    end
    // wrap-corrected advance, small backward steps count as zero
    pdiff = {1'b0, phase_i} - {1'b0, pp};
    adv   = (pdiff[16] && pdiff[15]) ? 16'd0 : pdiff[15:0];
    pp    = phase_i;
    hsum  = {1'b0, hel} + (EB+1)'(adv);
    esum  = {1'b0, el} + (EB+1)'(adv);
    hel   = hsum[EB] ? '1 : hsum[EB-1:0];
    el    = esum[EB] ? '1 : esum[EB-1:0];
    if (ht_q != '0 && hel >= EB'(ht_q) && stg != STG_RELEASE && stg != STG_END) begin
      stg = (rt_q != '0) ? STG_RELEASE : STG_END;
      el  = '0;
    end
    unique case (stg)
      STG_ATTACK: begin
        if (el >= EB'(at_q)) begin
          el = el - EB'(at_q);
          if (dt_q == '0) begin
            stg = STG_SUSTAIN;
            job = JOB_SUS;
          end else begin
            stg = STG_DECAY;
            lvl = gp;
            rs  = gp;
          end
        end else begin
          job = JOB_EASE_A;
        end
      end
      STG_DECAY: begin
        if (el >= EB'(dt_q)) begin
          el  = el - EB'(dt_q);
          stg = STG_SUSTAIN;
          job = JOB_SUS;
        end else begin
          job = JOB_EASE_D;
        end
      end
      STG_SUSTAIN: job = JOB_SUS;
      STG_RELEASE: begin
        if (el >= EB'(rt_q)) stg = STG_END;
        else                 job = JOB_EASE_R;
      end
      default: stg = STG_END;
    endcase
  end

  // ---------------------------------------------------------------------------
  // operand selection and result shaping
  // ---------------------------------------------------------------------------
  logic [16:0] crv, tsel, mag, mix_s, mix_e;
  logic        neg;
  logic [52:0] rnd;
  logic [16:0] sus_n;
  logic [37:0] dv, nv, tv, denv;
  logic        bend_bad;
  logic [34:0] p2x3;
  logic [51:0] w48, wr;
  logic [19:0] wf;
  logic [16:0] wn;
  seq_e        first_seq;

  always_comb begin
    unique case (job_q)
      JOB_EASE_A: begin crv = ac_q; tsel = at_q; end
      JOB_EASE_D: begin crv = dc_q; tsel = dt_q; end
      default:    begin crv = rc_q; tsel = rt_q; end
    endcase
    unique case (job_q)
      JOB_EASE_A: begin mix_s = '0;   mix_e = gp_q;  end
      JOB_EASE_D: begin mix_s = gp_q; mix_e = sus_q; end
      default:    begin mix_s = rs_q; mix_e = '0;    end
    endcase
  end

  assign neg   = crv[16];
  assign mag   = neg ? 17'(-crv) : crv;
  assign rnd   = acc_q + 53'd32768;
  assign sus_n = (|rnd[52:33]) ? 17'h1FFFF : rnd[32:16];

  // bend terms, two's complement over 38 bits
  assign dv   = neg ? 38'h1_0000_0000 + 38'(qb_q) : 38'h1_0000_0000 - 38'(qb_q);
  assign nv   = neg ? dv - 38'(qa_q) : dv + 38'(qa_q);
  assign tv   = 38'(acc_q[50:16]);
  assign denv = neg ? dv - tv : dv + tv;
  assign bend_bad = denv[37] || (denv == '0) || nv[37] || (nv == '0);

  // cubic ease weight w = p/2 + 3p^2/2 - p^3
  assign p2x3 = 35'(p2_q) + 35'({p2_q, 1'b0});
  assign w48  = 52'({p_q, 31'b0}) + 52'({p2x3, 15'b0}) - 52'(acc_q);
  assign wr   = w48 + 52'h0_0000_8000_0000;
  assign wf   = wr[51:32];
  assign wn   = (wf > 20'(OneQ16)) ? OneQ16 : wf[16:0];

  always_comb begin
    unique case (job)
      JOB_SUS, JOB_EASE_D:    first_seq = S_SUS;
      JOB_EASE_A, JOB_EASE_R: first_seq = S_FRAC;
      default:                first_seq = S_OUT;
    endcase
  end

  always_comb begin
    unique case (seq_q)
      S_FRAC, S_BDIV: op_fin = run_q && (div_cnt_q == '0);
      default:        op_fin = run_q && (mul_b_q == '0);
    endcase
  end

  // divider step
  logic [36:0] dsh, rem_n;
  logic        dge;
  assign dsh   = {rem_q[35:0], num_q[51]};
  assign dge   = (dsh >= {1'b0, dsr_q});
  assign rem_n = dge ? dsh - {1'b0, dsr_q} : dsh;

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= S_IDLE;
      run_q       <= 1'b0;
      mul_b_q     <= '0;
      div_cnt_q   <= '0;
      stage_q     <= STG_END;
      gp_q        <= '0;
      rs_q        <= '0;
      last_q      <= '0;
      prev_q      <= '0;
      el_q        <= '0;
      hold_q      <= '0;
      job_q       <= JOB_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (mul_b_q != '0)   mul_b_q   <= mul_b_q >> 1;
      if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - 6'd1;
      if (seq_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)          out_valid_q <= 1'b0;
      unique case (seq_q)
        S_IDLE: begin
          if (in_acc) begin
            stage_q <= stg;
            gp_q    <= gp;
            rs_q    <= rs;
            last_q  <= gate_level_i;
            prev_q  <= pp;
            el_q    <= el;
            hold_q  <= hel;
            job_q   <= job;
            seq_q   <= first_seq;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (job_q == JOB_SUS || job_q == JOB_EASE_D ||
                (job_q == JOB_EASE_A && p_q != '0)) begin
              rs_q <= lvl_q;
            end
            seq_q <= S_IDLE;
          end
        end
        default: begin
          if (!run_q) begin
            run_q <= 1'b1;
            unique case (seq_q)
              S_SUS:   mul_b_q   <= 18'(sl_q);
              S_FRAC:  div_cnt_q <= 6'd16;
              S_QB:    mul_b_q   <= 18'(mag);
              S_QA:    mul_b_q   <= {mag, 1'b0};
              S_T:     mul_b_q   <= 18'(v_q);
              S_NUM:   mul_b_q   <= 18'(v_q);
              S_BDIV:  div_cnt_q <= 6'd52;
              S_P2:    mul_b_q   <= 18'(p_q);
              S_P3:    mul_b_q   <= 18'(p_q);
              S_MIX1:  mul_b_q   <= 18'(OneQ16 - w_q);
              default: mul_b_q   <= 18'(w_q);
            endcase
          end else if (op_fin) begin
            run_q <= 1'b0;
            unique case (seq_q)
              S_SUS:   seq_q <= (job_q == JOB_SUS) ? S_OUT : S_FRAC;
              S_FRAC:  seq_q <= (crv == '0) ? S_P2 : S_QB;
              S_QB:    seq_q <= S_QA;
              S_QA:    seq_q <= S_T;
              S_T:     seq_q <= bend_bad ? S_P2 : S_NUM;
              S_NUM:   seq_q <= S_BDIV;
              S_BDIV:  seq_q <= S_P2;
              S_P2:    seq_q <= S_P3;
              S_P3:    seq_q <= S_MIX1;
              S_MIX1:  seq_q <= S_MIX2;
              default: seq_q <= S_OUT;
            endcase
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mul_b_q != '0) begin
      if (mul_b_q[0]) acc_q <= acc_q + mul_a_q;
      mul_a_q <= mul_a_q << 1;
    end
    if (div_cnt_q != '0) begin
      rem_q <= rem_n;
      num_q <= num_q << 1;
      ovf_q <= ovf_q | dq_q[16];
      dq_q  <= {dq_q[15:0], dge};
    end
    if (seq_q == S_IDLE && in_acc) lvl_q <= lvl;
    if (seq_q == S_OUT && out_free) begin
      out_level_q  <= lvl_q;
      out_active_q <= (stage_q != STG_END);
      out_stage_q  <= stage_q;
    end
    if (!run_q) begin
      unique case (seq_q)
        S_SUS:  begin mul_a_q <= 53'(gp_q); acc_q <= '0; end
        S_FRAC: begin
          rem_q <= 37'(el_q[16:0]);
          num_q <= '0;
          dq_q  <= '0;
          ovf_q <= 1'b0;
          dsr_q <= 36'(tsel);
        end
        S_QB:   begin mul_a_q <= 53'(KB);    acc_q <= '0; end
        S_QA:   begin mul_a_q <= 53'(KA);    acc_q <= '0; end
        S_T:    begin mul_a_q <= 53'(qa_q);  acc_q <= '0; end
        S_NUM:  begin mul_a_q <= 53'(n_q);   acc_q <= '0; end
        S_BDIV: begin
          rem_q <= '0;
          num_q <= acc_q[51:0] + 52'(den_q >> 1);
          dq_q  <= '0;
          ovf_q <= 1'b0;
          dsr_q <= den_q;
        end
        S_P2:   begin mul_a_q <= 53'(p_q);   acc_q <= '0; end
        S_P3:   begin mul_a_q <= 53'(p2_q);  acc_q <= '0; end
        S_MIX1: begin mul_a_q <= 53'(mix_s); acc_q <= '0; end
        S_MIX2: mul_a_q <= 53'(mix_e);
        default: ;
      endcase
    end else if (op_fin) begin
      unique case (seq_q)
        S_SUS: begin
          sus_q <= sus_n;
          lvl_q <= sus_n;
        end
        S_FRAC: begin
          v_q <= {1'b0, dq_q[15:0]};
          p_q <= {1'b0, dq_q[15:0]};
        end
        S_QB: qb_q <= rnd[48:16];
        S_QA: qa_q <= rnd[49:16];
        S_T: begin
          n_q   <= nv[34:0];
          den_q <= denv[35:0];
          if (bend_bad) p_q <= v_q;
        end
        S_BDIV: p_q <= (ovf_q || dq_q > OneQ16) ? OneQ16 : dq_q;
        S_P2:   p2_q <= acc_q[32:0];
        S_P3:   w_q <= wn;
        S_MIX2: lvl_q <= rnd[32:16];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("sequencer took a beat without leaving idle");

  a_active_matches_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (voice_active_o == (env_stage_o != STG_END)))
    else $error("voice_active disagrees with env_stage");

  a_ended_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !voice_active_o) |-> (level_o == '0))
    else $error("ended voice with nonzero level");

  a_units_quiet_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == S_IDLE) |-> (mul_b_q == '0 && div_cnt_q == '0))
    else $error("serial unit still running while idle");

endmodule
